### sv/mi3_pkg.sv
// Shared constants and types for the 3x3 matrix inverse pipeline.
// No dependencies; used by every module of the block.
package mi3_pkg;

    localparam int unsigned N_ELEM = 9;
    localparam int unsigned N_ROW  = 3;

    // Cofactor k = m[CF_A[k]] * m[CF_B[k]] - m[CF_C[k]] * m[CF_D[k]],
    // with the matrix flattened row-major (index = 3*row + col).
    localparam int unsigned CF_A [N_ELEM] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
    localparam int unsigned CF_B [N_ELEM] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
    localparam int unsigned CF_C [N_ELEM] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
    localparam int unsigned CF_D [N_ELEM] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

    // Control that travels with each element through the divider
    typedef struct packed {
        logic zero;   // determinant is zero
        logic neg;    // cofactor and determinant differ in sign
    } div_ctl_t;

    // Status that comes out of the divider per element
    typedef struct packed {
        logic zero;   // determinant was zero, value forced to 0
        logic sat;    // value was clipped
    } elem_flags_t;

endpackage

### sv/mi3_cofactor.sv
// Two-stage cofactor unit: eighteen products, then nine differences.
// Depends on mi3_pkg for the cofactor index tables.
module mi3_cofactor #(
    parameter int DW = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    input  logic [mi3_pkg::N_ELEM-1:0][DW-1:0]     mat,
    output logic                                   out_valid,
    output logic [mi3_pkg::N_ROW-1:0][DW-1:0]      row0,
    output logic [mi3_pkg::N_ELEM-1:0][2*DW:0]     cof
);

    logic signed [2*DW-1:0] pa_reg [mi3_pkg::N_ELEM];
    logic signed [2*DW-1:0] pb_reg [mi3_pkg::N_ELEM];
    logic [mi3_pkg::N_ROW-1:0][DW-1:0]  r0a_reg;
    logic [mi3_pkg::N_ROW-1:0][DW-1:0]  r0b_reg;
    logic [mi3_pkg::N_ELEM-1:0][2*DW:0] cof_reg;
    logic v1_reg;
    logic v2_reg;

    // valid pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    // stage 1: products; stage 2: differences, sign-extended one bit
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < mi3_pkg::N_ELEM; i++)
        begin
            pa_reg[i] <= $signed(mat[mi3_pkg::CF_A[i]]) * $signed(mat[mi3_pkg::CF_B[i]]);
            pb_reg[i] <= $signed(mat[mi3_pkg::CF_C[i]]) * $signed(mat[mi3_pkg::CF_D[i]]);
            cof_reg[i] <= {pa_reg[i][2*DW-1], pa_reg[i]} - {pb_reg[i][2*DW-1], pb_reg[i]};
        end
        for (int j = 0; j < mi3_pkg::N_ROW; j++)
        begin
            r0a_reg[j] <= mat[j];
        end
        r0b_reg <= r0a_reg;
    end

    assign out_valid = v2_reg;
    assign row0      = r0b_reg;
    assign cof       = cof_reg;

endmodule

### sv/mi3_det.sv
// Three-stage determinant: split products of row 0 by its cofactors,
// recombination, and the final sum. Cofactors are delayed alongside.
// Depends on mi3_pkg.
module mi3_det #(
    parameter int DW = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    input  logic [mi3_pkg::N_ROW-1:0][DW-1:0]      row0,
    input  logic [mi3_pkg::N_ELEM-1:0][2*DW:0]     cof,
    output logic                                   out_valid,
    output logic [3*DW+2:0]                        det,
    output logic [mi3_pkg::N_ELEM-1:0][2*DW:0]     cof_out
);

    localparam int PW   = 3 * DW + 1;
    localparam int DETW = 3 * DW + 3;

    logic signed [2*DW:0]   plo_next [mi3_pkg::N_ROW];
    logic signed [2*DW:0]   phi_next [mi3_pkg::N_ROW];
    logic signed [2*DW:0]   plo_reg  [mi3_pkg::N_ROW];
    logic signed [2*DW:0]   phi_reg  [mi3_pkg::N_ROW];
    logic signed [PW-1:0]   prod_reg [mi3_pkg::N_ROW];
    logic signed [DETW-1:0] det_reg;
    logic [mi3_pkg::N_ELEM-1:0][2*DW:0] cd_reg [3];
    logic [2:0] v_reg;

    // cofactor split into a signed high half and an unsigned low half
    always_comb
    begin
        logic [2*DW:0]      c;
        logic signed [DW:0] lo;
        logic signed [DW:0] hi;
        for (int j = 0; j < mi3_pkg::N_ROW; j++)
        begin
            c  = cof[3*j];
            lo = $signed({1'b0, c[DW-1:0]});
            hi = $signed(c[2*DW:DW]);
            plo_next[j] = $signed(row0[j]) * lo;
            phi_next[j] = $signed(row0[j]) * hi;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < mi3_pkg::N_ROW; j++)
        begin
            plo_reg[j]  <= plo_next[j];
            phi_reg[j]  <= phi_next[j];
            prod_reg[j] <= (PW'(phi_reg[j]) <<< DW) + PW'(plo_reg[j]);
        end
        det_reg   <= DETW'(prod_reg[0]) + DETW'(prod_reg[1]) + DETW'(prod_reg[2]);
        cd_reg[0] <= cof;
        cd_reg[1] <= cd_reg[0];
        cd_reg[2] <= cd_reg[1];
    end

    assign out_valid = v_reg[2];
    assign det       = det_reg;
    assign cof_out   = cd_reg[2];

endmodule

### sv/mi3_div.sv
// Pipelined restoring divider for one inverse element: range check,
// one quotient bit per stage, then sign, saturation and singular masking.
// Depends on mi3_pkg for the control and flag structs.
module mi3_div #(
    parameter int DW   = 32,
    parameter int NW   = 100,
    parameter int DENW = 100,
    parameter int XW   = 132
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [NW-1:0]         num,
    input  logic [DENW-1:0]       den,
    input  mi3_pkg::div_ctl_t     ctl,
    output logic                  out_valid,
    output logic [DW-1:0]         quo,
    output mi3_pkg::elem_flags_t  flags
);

    logic [XW-1:0]        rem_reg [DW];
    logic [DENW-1:0]      den_reg [DW];
    logic [DW-1:0]        q_reg   [1:DW];
    logic                 ovf_reg [DW+1];
    mi3_pkg::div_ctl_t    ctl_reg [DW+1];
    logic [DW:0]          vld_reg;
    logic [XW-1:0]        sub     [DW];
    logic [DW-1:0]        ge;

    logic [DW-1:0]        quo_next;
    mi3_pkg::elem_flags_t flags_next;
    logic [DW-1:0]        quo_reg;
    mi3_pkg::elem_flags_t flags_reg;
    logic                 out_valid_reg;

    // trial subtrahend and compare for each bit stage
    always_comb
    begin
        for (int s = 0; s < DW; s++)
        begin
            sub[s] = XW'(den_reg[s]) << (DW - 1 - s);
            ge[s]  = (rem_reg[s] >= sub[s]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            vld_reg       <= {vld_reg[DW-1:0], in_valid};
            out_valid_reg <= vld_reg[DW];
        end
    end

    // range check, then the bit stages
    always_ff @(posedge clk)
    begin
        rem_reg[0] <= XW'(num);
        den_reg[0] <= den;
        ovf_reg[0] <= (XW'(num) >= (XW'(den) << DW));
        ctl_reg[0] <= ctl;
        for (int s = 0; s < DW - 1; s++)
        begin
            rem_reg[s+1] <= ge[s] ? (rem_reg[s] - sub[s]) : rem_reg[s];
            den_reg[s+1] <= den_reg[s];
        end
        q_reg[1] <= {{(DW-1){1'b0}}, ge[0]};
        for (int s = 1; s < DW; s++)
        begin
            q_reg[s+1] <= {q_reg[s][DW-2:0], ge[s]};
        end
        for (int s = 0; s < DW; s++)
        begin
            ovf_reg[s+1] <= ovf_reg[s];
            ctl_reg[s+1] <= ctl_reg[s];
        end
    end

    // sign, clip to the signed range, zero on a singular matrix
    always_comb
    begin
        logic [DW-1:0] q;
        logic          neg;
        logic          big;
        logic [DW-1:0] mag;
        q   = q_reg[DW];
        neg = ctl_reg[DW].neg & (ovf_reg[DW] | (q != '0));
        big = neg ? (q[DW-1] & (|q[DW-2:0])) : q[DW-1];
        flags_next.sat  = ovf_reg[DW] | big;
        flags_next.zero = ctl_reg[DW].zero;
        if (flags_next.sat)
        begin
            mag = neg ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        end
        else
        begin
            mag = q;
        end
        quo_next = neg ? (~mag + DW'(1)) : mag;
        if (ctl_reg[DW].zero)
        begin
            quo_next       = '0;
            flags_next.sat = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg   <= quo_next;
        flags_reg <= flags_next;
    end

    assign out_valid = out_valid_reg;
    assign quo       = quo_reg;
    assign flags     = flags_reg;

endmodule

### sv/matrix_inverse_3x3.sv
// 3x3 fixed-point matrix inverse by the adjugate, fully pipelined.
// Throughput: one matrix per clock; busy is never raised.
// The latency is set by the quotient array, one quotient bit per stage.
// rst_n clears every valid bit; data registers are not reset.
// Depends on mi3_pkg, mi3_cofactor, mi3_det and mi3_div.
module matrix_inverse_3x3 #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [DATA_WIDTH-1:0] in_r0c0,
    input  logic signed [DATA_WIDTH-1:0] in_r0c1,
    input  logic signed [DATA_WIDTH-1:0] in_r0c2,
    input  logic signed [DATA_WIDTH-1:0] in_r1c0,
    input  logic signed [DATA_WIDTH-1:0] in_r1c1,
    input  logic signed [DATA_WIDTH-1:0] in_r1c2,
    input  logic signed [DATA_WIDTH-1:0] in_r2c0,
    input  logic signed [DATA_WIDTH-1:0] in_r2c1,
    input  logic signed [DATA_WIDTH-1:0] in_r2c2,
    output logic                         done,
    output logic signed [DATA_WIDTH-1:0] inv_r0c0,
    output logic signed [DATA_WIDTH-1:0] inv_r0c1,
    output logic signed [DATA_WIDTH-1:0] inv_r0c2,
    output logic signed [DATA_WIDTH-1:0] inv_r1c0,
    output logic signed [DATA_WIDTH-1:0] inv_r1c1,
    output logic signed [DATA_WIDTH-1:0] inv_r1c2,
    output logic signed [DATA_WIDTH-1:0] inv_r2c0,
    output logic signed [DATA_WIDTH-1:0] inv_r2c1,
    output logic signed [DATA_WIDTH-1:0] inv_r2c2,
    output logic                         singular,
    output logic                         saturated
);

    localparam int DW      = DATA_WIDTH;
    localparam int CW      = 2 * DW + 1;
    localparam int DETW    = 3 * DW + 3;
    localparam int NUMA    = CW + 2 * FRAC_BITS + 1;
    localparam int NW      = ((NUMA > DETW) ? NUMA : DETW) + 1;
    localparam int DENW    = DETW + 1;
    localparam int XW      = (NW > DENW + DW) ? NW : (DENW + DW);
    localparam int LATENCY = DW + 9;

    logic [mi3_pkg::N_ELEM-1:0][DW-1:0] mat;
    logic                               cf_valid;
    logic [mi3_pkg::N_ROW-1:0][DW-1:0]  cf_row0;
    logic [mi3_pkg::N_ELEM-1:0][CW-1:0] cf_cof;
    logic                               dt_valid;
    logic [DETW-1:0]                    dt_det;
    logic [mi3_pkg::N_ELEM-1:0][CW-1:0] dt_cof;

    logic [NW-1:0]          num_next [mi3_pkg::N_ELEM];
    mi3_pkg::div_ctl_t      ctl_next [mi3_pkg::N_ELEM];
    logic [DENW-1:0]        den_next;
    logic [NW-1:0]          num_reg  [mi3_pkg::N_ELEM];
    mi3_pkg::div_ctl_t      ctl_reg  [mi3_pkg::N_ELEM];
    logic [DENW-1:0]        den_reg;
    logic                   prep_valid_reg;

    logic [mi3_pkg::N_ELEM-1:0]   dv_valid;
    logic [DW-1:0]                dv_quo   [mi3_pkg::N_ELEM];
    mi3_pkg::elem_flags_t         dv_flags [mi3_pkg::N_ELEM];

    logic [DW-1:0]          inv_reg [mi3_pkg::N_ELEM];
    logic                   sat_next;
    logic                   sat_reg;
    logic                   sing_reg;
    logic                   done_reg;

    // fully pipelined, never holds off a transaction
    assign busy = 1'b0;

    assign mat[0] = in_r0c0;
    assign mat[1] = in_r0c1;
    assign mat[2] = in_r0c2;
    assign mat[3] = in_r1c0;
    assign mat[4] = in_r1c1;
    assign mat[5] = in_r1c2;
    assign mat[6] = in_r2c0;
    assign mat[7] = in_r2c1;
    assign mat[8] = in_r2c2;

    mi3_cofactor #(
        .DW (DW)
    ) u_cofactor (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start & ~busy),
        .mat       (mat),
        .out_valid (cf_valid),
        .row0      (cf_row0),
        .cof       (cf_cof)
    );

    mi3_det #(
        .DW (DW)
    ) u_det (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cf_valid),
        .row0      (cf_row0),
        .cof       (cf_cof),
        .out_valid (dt_valid),
        .det       (dt_det),
        .cof_out   (dt_cof)
    );

    // divider operands: |C| scaled with the rounding term, and 2|D|
    always_comb
    begin
        logic            dneg;
        logic [DETW-1:0] dabs;
        logic            dzero;
        logic [CW-1:0]   cv;
        logic [CW-1:0]   cabs;
        dneg     = dt_det[DETW-1];
        dabs     = dneg ? (~dt_det + DETW'(1)) : dt_det;
        dzero    = (dt_det == '0);
        den_next = DENW'(dabs) << 1;
        for (int i = 0; i < mi3_pkg::N_ELEM; i++)
        begin
            cv   = dt_cof[i];
            cabs = cv[CW-1] ? (~cv + CW'(1)) : cv;
            num_next[i]      = (NW'(cabs) << (2 * FRAC_BITS + 1)) + NW'(dabs);
            ctl_next[i].neg  = cv[CW-1] ^ dneg;
            ctl_next[i].zero = dzero;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_valid_reg <= 1'b0;
        end
        else
        begin
            prep_valid_reg <= dt_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < mi3_pkg::N_ELEM; i++)
        begin
            num_reg[i] <= num_next[i];
            ctl_reg[i] <= ctl_next[i];
        end
        den_reg <= den_next;
    end

    // nine quotient pipelines in parallel
    for (genvar i = 0; i < mi3_pkg::N_ELEM; i++)
    begin : g_div
        mi3_div #(
            .DW   (DW),
            .NW   (NW),
            .DENW (DENW),
            .XW   (XW)
        ) u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (prep_valid_reg),
            .num       (num_reg[i]),
            .den       (den_reg),
            .ctl       (ctl_reg[i]),
            .out_valid (dv_valid[i]),
            .quo       (dv_quo[i]),
            .flags     (dv_flags[i])
        );
    end

    // collect the clip flags of all elements
    always_comb
    begin
        sat_next = 1'b0;
        for (int i = 0; i < mi3_pkg::N_ELEM; i++)
        begin
            sat_next = sat_next | dv_flags[i].sat;
        end
    end

    // result register, one strobe per transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv_valid[0];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < mi3_pkg::N_ELEM; i++)
        begin
            inv_reg[i] <= dv_quo[i];
        end
        sat_reg  <= sat_next;
        sing_reg <= dv_flags[0].zero;
    end

    assign done      = done_reg;
    assign inv_r0c0  = inv_reg[0];
    assign inv_r0c1  = inv_reg[1];
    assign inv_r0c2  = inv_reg[2];
    assign inv_r1c0  = inv_reg[3];
    assign inv_r1c1  = inv_reg[4];
    assign inv_r1c2  = inv_reg[5];
    assign inv_r2c0  = inv_reg[6];
    assign inv_r2c1  = inv_reg[7];
    assign inv_r2c2  = inv_reg[8];
    assign singular  = sing_reg;
    assign saturated = sat_reg;

`ifndef SYNTH
    // every accepted matrix produces its result a fixed time later
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LATENCY done)
        else $error("result strobe missing at fixed latency");

    // a singular matrix never reports clipping
    a_sing_nosat: assert property (@(posedge clk) disable iff (!rst_n)
        done && singular |-> !saturated)
        else $error("singular result flagged as saturated");

    // a singular matrix returns all zeros
    a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && singular |-> inv_r0c0 == 0 && inv_r0c1 == 0 && inv_r0c2 == 0 &&
            inv_r1c0 == 0 && inv_r1c1 == 0 && inv_r1c2 == 0 &&
            inv_r2c0 == 0 && inv_r2c1 == 0 && inv_r2c2 == 0)
        else $error("singular result not zero");
`endif

endmodule

### dv/tb_matrix_inverse_3x3.sv
// Self-checking testbench for matrix_inverse_3x3: directed table plus random matrices,
// each result compared against a typed-in answer or an exact adjugate/determinant predictor.
// Depends on mi3_pkg and the matrix_inverse_3x3 RTL.
module tb_matrix_inverse_3x3;

    localparam int DW = 32;
    localparam int FB = 16;
    localparam int N_RANDOM = 1630;

    typedef logic signed [DW-1:0] elem_t;
    typedef elem_t mat_t [mi3_pkg::N_ELEM];

    typedef struct {
        elem_t inv [mi3_pkg::N_ELEM];
        logic  sing;
        logic  sat;
    } inverse_t;

    // directed row: matrix, and an optional typed-in answer
    typedef struct {
        mat_t     m;
        logic     has_ans;
        inverse_t ans;
    } vec_row_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic done;
    elem_t in_e [mi3_pkg::N_ELEM];
    elem_t out_e [mi3_pkg::N_ELEM];
    logic singular;
    logic saturated;

    inverse_t pending_inv [$];
    int errors;
    int active_gap;

    matrix_inverse_3x3 #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .in_r0c0(in_e[0]), .in_r0c1(in_e[1]), .in_r0c2(in_e[2]),
        .in_r1c0(in_e[3]), .in_r1c1(in_e[4]), .in_r1c2(in_e[5]),
        .in_r2c0(in_e[6]), .in_r2c1(in_e[7]), .in_r2c2(in_e[8]),
        .done(done),
        .inv_r0c0(out_e[0]), .inv_r0c1(out_e[1]), .inv_r0c2(out_e[2]),
        .inv_r1c0(out_e[3]), .inv_r1c1(out_e[4]), .inv_r1c2(out_e[5]),
        .inv_r2c0(out_e[6]), .inv_r2c1(out_e[7]), .inv_r2c2(out_e[8]),
        .singular(singular), .saturated(saturated)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20000000;
        $display("[matrix_inverse_3x3] ERROR");
        $finish;
    end

    // Exact inverse: cofactors need ~2*DW bits, determinant ~3*DW; scaled numerator more.
    function automatic inverse_t invert_matrix(mat_t m);
        inverse_t r;
        logic signed [255:0] e [mi3_pkg::N_ELEM];
        logic signed [255:0] cf [mi3_pkg::N_ELEM];
        logic signed [255:0] det;
        logic [255:0] num, den, q, lim;
        logic neg;
        for (int i = 0; i < mi3_pkg::N_ELEM; i++)
            e[i] = m[i];
        for (int k = 0; k < mi3_pkg::N_ELEM; k++)
            cf[k] = e[mi3_pkg::CF_A[k]] * e[mi3_pkg::CF_B[k]]
                  - e[mi3_pkg::CF_C[k]] * e[mi3_pkg::CF_D[k]];
        det = e[0] * cf[0] + e[1] * cf[3] + e[2] * cf[6];
        r.sing = (det == 0);
        r.sat = 1'b0;
        for (int k = 0; k < mi3_pkg::N_ELEM; k++)
        begin
            r.inv[k] = '0;
            if (!r.sing)
            begin
                num = (cf[k] < 0) ? -cf[k] : cf[k];
                den = (det < 0) ? -det : det;
                num = num << (2 * FB);
                // round half away from zero
                q = (2 * num + den) / (2 * den);
                neg = ((cf[k] < 0) != (det < 0)) && (q != 0);
                lim = neg ? (256'd1 << (DW - 1)) : ((256'd1 << (DW - 1)) - 1);
                if (q > lim)
                begin
                    q = lim;
                    r.sat = 1'b1;
                end
                r.inv[k] = neg ? elem_t'(-q) : elem_t'(q);
            end
        end
        return r;
    endfunction

    function automatic mat_t diag_matrix(elem_t a, elem_t b, elem_t c);
        mat_t m;
        foreach (m[i])
            m[i] = '0;
        m[0] = a;
        m[4] = b;
        m[8] = c;
        return m;
    endfunction

    function automatic elem_t rand_elem();
        case ($urandom_range(0, 5))
            0: return elem_t'($urandom);
            1: return elem_t'($signed($urandom_range(0, 32'h3_0000)) - 32'sh1_8000);
            2: return elem_t'($signed($urandom_range(0, 255)) - 128);
            3: return ($urandom_range(0, 1)) ? 32'sh7fff_ffff : 32'sh8000_0000;
            4: return elem_t'(($signed($urandom_range(0, 8)) - 4) <<< FB);
            default: return elem_t'($urandom) >>> $urandom_range(0, 31);
        endcase
    endfunction

    function automatic mat_t rand_matrix();
        mat_t m;
        int src, dst;
        foreach (m[i])
            m[i] = rand_elem();
        // sometimes force singular: copy a row or zero a column
        case ($urandom_range(0, 9))
            0:
            begin
                src = $urandom_range(0, 2);
                dst = (src + 1 + $urandom_range(0, 1)) % 3;
                for (int c = 0; c < 3; c++)
                    m[3*dst + c] = m[3*src + c];
            end
            1:
            begin
                dst = $urandom_range(0, 2);
                for (int c = 0; c < 3; c++)
                    m[c*3 + dst] = '0;
            end
            default: ;
        endcase
        return m;
    endfunction

    // One transaction: hold start until accepted, then maybe gap
    task automatic send_matrix(mat_t m, inverse_t want);
        for (int i = 0; i < mi3_pkg::N_ELEM; i++)
            in_e[i] <= m[i];
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_inv.push_back(want);
        if (active_gap == 0)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            active_gap = $urandom_range(0, 20);
        end
        else
            active_gap--;
    endtask

    // Result checker
    always @(posedge clk)
    begin
        inverse_t want;
        if (rst_n && done)
        begin
            if (pending_inv.size() == 0)
            begin
                $display("%0t: unexpected result", $time);
                errors++;
            end
            else
            begin
                want = pending_inv.pop_front();
                for (int k = 0; k < mi3_pkg::N_ELEM; k++)
                    if (out_e[k] !== want.inv[k])
                    begin
                        $display("%0t: inv[%0d] expected %h actual %h",
                                 $time, k, want.inv[k], out_e[k]);
                        errors++;
                    end
                if (singular !== want.sing)
                begin
                    $display("%0t: singular expected %b actual %b",
                             $time, want.sing, singular);
                    errors++;
                end
                if (saturated !== want.sat)
                begin
                    $display("%0t: saturated expected %b actual %b",
                             $time, want.sat, saturated);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        vec_row_t vecs [$];
        vec_row_t row;
        inverse_t exp_r;
        mat_t m;
        int wait_cnt;

        errors = 0;
        active_gap = 0;
        rst_n = 1'b0;
        start = 1'b0;
        foreach (in_e[i])
            in_e[i] = '0;

        // singular zero matrix: answer read straight off
        row.m = diag_matrix(0, 0, 0);
        row.has_ans = 1'b1;
        foreach (exp_r.inv[i])
            exp_r.inv[i] = '0;
        exp_r.sing = 1'b1;
        exp_r.sat = 1'b0;
        row.ans = exp_r;
        vecs.push_back(row);
        // identity gives identity
        row.m = diag_matrix(32'sh1_0000, 32'sh1_0000, 32'sh1_0000);
        exp_r.inv = row.m;
        exp_r.sing = 1'b0;
        row.ans = exp_r;
        vecs.push_back(row);
        // tiny diagonal: inverse overflows high and low
        row.m = diag_matrix(1, -1, 1);
        exp_r.inv = diag_matrix(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff);
        exp_r.sat = 1'b1;
        row.ans = exp_r;
        vecs.push_back(row);
        // remaining rows checked by the predictor
        row.has_ans = 1'b0;
        row.m = diag_matrix(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
        vecs.push_back(row);
        row.m = diag_matrix(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
        vecs.push_back(row);
        row.m = diag_matrix(32'sh2_0000, -32'sh4_0000, 32'sh3_0000);
        vecs.push_back(row);
        row.m = diag_matrix(3, 32'sh7fff_ffff, -32'sh8000_0000);
        vecs.push_back(row);
        foreach (m[i])
            m[i] = 32'sh8000_0000;
        row.m = m;
        vecs.push_back(row);
        foreach (m[i])
            m[i] = elem_t'((i * 7 + 1) << FB) ^ elem_t'(i);
        row.m = m;
        vecs.push_back(row);
        foreach (m[i])
            m[i] = (i % 2) ? 32'sh7fff_ffff : 32'sh8000_0000;
        row.m = m;
        vecs.push_back(row);
        foreach (m[i])
            m[i] = (i == 0) ? 1 : ((i % 4 == 0) ? -1 : 0);
        row.m = m;
        vecs.push_back(row);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // typed-in answers go straight to the checker, the rest through the predictor
        foreach (vecs[v])
        begin
            if (vecs[v].has_ans)
                exp_r = vecs[v].ans;
            else
                exp_r = invert_matrix(vecs[v].m);
            send_matrix(vecs[v].m, exp_r);
        end
        for (int n = 0; n < N_RANDOM; n++)
        begin
            m = rand_matrix();
            send_matrix(m, invert_matrix(m));
        end
        start <= 1'b0;

        wait_cnt = 0;
        while (pending_inv.size() != 0 && wait_cnt < 10000)
        begin
            @(posedge clk);
            wait_cnt++;
        end
        repeat (DW + 20) @(posedge clk);
        if (errors == 0 && pending_inv.size() == 0)
            $display("[matrix_inverse_3x3] OK");
        else
            $display("[matrix_inverse_3x3] ERROR");
        $finish;
    end
endmodule
